/* rtl/assert_macros.svh */
// Assertion helpers for the merge-cost block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// explicit clock and reset
`define HMC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// modules whose ports are named clock and reset
`define HMC_ASSERT_CR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`else

`define HMC_ASSERT(lbl, clk, rst, prop, msg)
`define HMC_ASSERT_CR(lbl, prop, msg)

`endif

`endif

/* rtl/hmc_pkg.sv */
`timescale 1ns / 1ps

package hmc_pkg;

   localparam int MAX_ITEMS   = 256;
   localparam int LENGTH_BITS = 32;

   localparam int STICK_W = 32;
   localparam int COST_W  = 48;
   localparam int ENTRY_W = COST_W;
   localparam int IDX_W   = $clog2(MAX_ITEMS);
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int USED_BITS = (LENGTH_BITS < STICK_W) ? LENGTH_BITS : STICK_W;

   typedef struct packed {
      logic [STICK_W-1:0] stick_length;
      logic               last_item;
   } req_word_type;

   typedef struct packed {
      logic [COST_W-1:0] total_cost;
      logic              overflow;
   } rsp_word_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0] wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } ram_req_type;

endpackage

/* rtl/hmc_ram.sv */
`timescale 1ns / 1ps

module hmc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 48,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/hmc_heap_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hmc_heap_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hmc_pkg::req_word_type       req_word,
   output logic                        res_valid,
   input  logic                        res_ready,
   output hmc_pkg::rsp_word_type       res_word,
   output hmc_pkg::ram_req_type        ram_req,
   input  logic [hmc_pkg::ENTRY_W-1:0] ram_rdata
);

   import hmc_pkg::*;

   localparam int LW = IDX_W + 2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_CHK,
      S_PUSH_CMP,
      S_PUSH_END,
      S_MERGE,
      S_POP_RD0,
      S_POP_RDL,
      S_POP_LAST,
      S_SIFT_CHK,
      S_SIFT_L,
      S_SIFT_R,
      S_POP_END,
      S_COST,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      CTX_LOAD,
      CTX_POP_A,
      CTX_POP_B,
      CTX_SUM
   } ctx_type;

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   ctx_type            ctx_ff, ctx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [ENTRY_W-1:0] val_ff, val_in;
   logic [ENTRY_W-1:0] top_ff, top_in;
   logic [ENTRY_W-1:0] a_ff, a_in;
   logic [ENTRY_W-1:0] lval_ff, lval_in;

   logic [ENTRY_W-1:0] len;
   logic [IDX_W-1:0]   up_idx;
   logic [LW-1:0]      l_wide, r_wide, cnt_wide;
   logic               pick_r;
   logic [ENTRY_W-1:0] m_val;
   logic [IDX_W-1:0]   m_idx;

   assign len      = ENTRY_W'(req_word.stick_length[USED_BITS-1:0]);
   assign up_idx   = (pos_ff - 1'b1) >> 1;
   assign l_wide   = {1'b0, pos_ff, 1'b1};
   assign r_wide   = l_wide + 1'b1;
   assign cnt_wide = LW'(count_ff);

   // smaller child: left data is held in lval_ff when the right one is read
   assign pick_r = (state_ff == S_SIFT_R) && (ram_rdata < lval_ff);
   assign m_val  = ((state_ff == S_SIFT_R) && !pick_r) ? lval_ff : ram_rdata;
   assign m_idx  = pick_r ? r_wide[IDX_W-1:0] : l_wide[IDX_W-1:0];

   assign res_word.total_cost = cost_ff;
   assign res_word.overflow   = ovf_ff;

   always_comb begin
      state_in  = state_ff;
      ctx_in    = ctx_ff;
      count_in  = count_ff;
      cost_in   = cost_ff;
      ovf_in    = ovf_ff;
      last_in   = last_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      top_in    = top_ff;
      a_in      = a_ff;
      lval_in   = lval_ff;
      ram_req   = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in = req_word.last_item;
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  pos_in   = count_ff[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
                  val_in   = len;
                  ctx_in   = CTX_LOAD;
                  state_in = S_PUSH_CHK;
               end else begin
                  // heap full: word dropped
                  ovf_in   = 1'b1;
                  state_in = req_word.last_item ? S_MERGE : S_IDLE;
               end
            end
         end

         S_PUSH_CHK: begin
            if (pos_ff == '0) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = pos_ff;
               ram_req.wdata = val_ff;
               state_in      = S_PUSH_END;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = up_idx;
               state_in      = S_PUSH_CMP;
            end
         end

         S_PUSH_CMP: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = pos_ff;
            if (ram_rdata <= val_ff) begin
               ram_req.wdata = val_ff;
               state_in      = S_PUSH_END;
            end else begin
               ram_req.wdata = ram_rdata;
               pos_in        = up_idx;
               state_in      = S_PUSH_CHK;
            end
         end

         S_PUSH_END: begin
            state_in = ((ctx_ff == CTX_LOAD) && !last_ff) ? S_IDLE : S_MERGE;
         end

         S_MERGE: begin
            if (count_ff > CNT_W'(1)) begin
               ctx_in   = CTX_POP_A;
               state_in = S_POP_RD0;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_POP_RD0: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = '0;
            state_in      = S_POP_RDL;
         end

         S_POP_RDL: begin
            top_in        = ram_rdata;
            ram_req.re    = 1'b1;
            ram_req.raddr = IDX_W'(count_ff - 1'b1);
            count_in      = count_ff - 1'b1;
            pos_in        = '0;
            state_in      = S_POP_LAST;
         end

         S_POP_LAST: begin
            val_in   = ram_rdata;
            state_in = S_SIFT_CHK;
         end

         S_SIFT_CHK: begin
            if (l_wide >= cnt_wide) begin
               if (count_ff != '0) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = pos_ff;
                  ram_req.wdata = val_ff;
               end
               state_in = S_POP_END;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = l_wide[IDX_W-1:0];
               state_in      = S_SIFT_L;
            end
         end

         S_SIFT_L, S_SIFT_R: begin
            if ((state_ff == S_SIFT_L) && (r_wide < cnt_wide)) begin
               lval_in       = ram_rdata;
               ram_req.re    = 1'b1;
               ram_req.raddr = r_wide[IDX_W-1:0];
               state_in      = S_SIFT_R;
            end else begin
               ram_req.we    = 1'b1;
               ram_req.waddr = pos_ff;
               if (m_val >= val_ff) begin
                  ram_req.wdata = val_ff;
                  state_in      = S_POP_END;
               end else begin
                  ram_req.wdata = m_val;
                  pos_in        = m_idx;
                  state_in      = S_SIFT_CHK;
               end
            end
         end

         S_POP_END: begin
            if (ctx_ff == CTX_POP_A) begin
               a_in     = top_ff;
               ctx_in   = CTX_POP_B;
               state_in = S_POP_RD0;
            end else begin
               val_in   = sat_add(a_ff, top_ff);
               state_in = S_COST;
            end
         end

         S_COST: begin
            cost_in  = sat_add(cost_ff, val_ff);
            pos_in   = count_ff[IDX_W-1:0];
            count_in = count_ff + 1'b1;
            ctx_in   = CTX_SUM;
            state_in = S_PUSH_CHK;
         end

         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               count_in = '0;
               cost_in  = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctx_ff   <= CTX_LOAD;
         count_ff <= '0;
         cost_ff  <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
         count_ff <= count_in;
         cost_ff  <= cost_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
      end
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      top_ff  <= top_in;
      a_ff    <= a_in;
      lval_ff <= lval_in;
   end

   `HMC_ASSERT_CR(a_count_range, count_ff <= CNT_W'(MAX_ITEMS), "heap count above capacity")
   `HMC_ASSERT_CR(a_wr_in_heap, ram_req.we |-> (CNT_W'(ram_req.waddr) < count_ff), "write outside heap")
   `HMC_ASSERT_CR(a_rd_in_heap, ram_req.re |-> (CNT_W'(ram_req.raddr) < count_ff), "read outside heap")
   `HMC_ASSERT(a_no_rw_same, clock, reset, !(ram_req.we && ram_req.re), "read and write in one cycle")

endmodule

/* rtl/huffman_merge_cost_top.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | word
// req     | in        | req_valid/req_ready  | stick_length[31:0], last_item
// rsp     | out       | rsp_valid/rsp_ready  | total_cost[47:0], overflow
//
// Load word: the new entry is sifted up from the end of the heap toward the root.
// Merge step: two pops, one push;
// the single read port of the heap RAM paces every sift walk.
// Reset clears count, cost and flags; the heap RAM is not cleared.
// A finished result waits in the output register while the next set loads;
// ready only when idle: stalls during each insert, merging, and a second result blocked.

module huffman_merge_cost_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hmc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hmc_pkg::rsp_word_type rsp_word
);

   import hmc_pkg::*;

   ram_req_type        ram_req;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               res_valid, res_ready;
   rsp_word_type       res_word;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   hmc_heap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_word  (res_word),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   hmc_ram #(
      .DEPTH (MAX_ITEMS),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // output register: takes a new result when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
